// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the console engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Console engine package
// Shared widths, operation codes, character codes, the reset color and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int CELL_W = 14;
    localparam int CHAR_W = 8;
    localparam int ID_W   = 2;

    typedef enum logic [1:0] {
        FUNC_PUT         = 2'd0,
        FUNC_SCROLL_UP   = 2'd1,
        FUNC_SCROLL_DOWN = 2'd2,
        FUNC_SELECT      = 2'd3
    } t_func;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'd7;

    typedef struct packed {
        logic              mem_write;
        logic [CELL_W-1:0] mem_cell;
        logic [CHAR_W-1:0] mem_char;
        logic [CHAR_W-1:0] mem_color;
        logic              crtc_update;
        logic [CELL_W-1:0] crtc_cursor;
        logic [CELL_W-1:0] crtc_start;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/tcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire                                   i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcc_update.sv
// ----------------------------------------------------------------------------
// Console state update
// Computes the new cursor and display start of one console and the result
// word for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_update import tcc_pkg::*; #(
    parameter int REGION_CELLS = 4096,
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_CELLS = 2000
) (
    input  var t_func                         i_func,
    input  wire                               i_id_ok,
    input  wire  [ID_W-1:0]                   i_k,
    input  wire  [ID_W-1:0]                   i_cur,
    input  wire  [CHAR_W-1:0]                 i_char,
    input  wire  [CHAR_W-1:0]                 i_color,
    input  wire  [CELL_W-1:0]                 i_base,
    input  wire  [$clog2(REGION_CELLS)-1:0]   i_off,
    input  wire  [$clog2(SCREEN_COLS)-1:0]    i_col,
    input  wire  [$clog2(REGION_CELLS)-1:0]   i_soff,
    output logic [$clog2(REGION_CELLS)-1:0]   o_off,
    output logic [$clog2(SCREEN_COLS)-1:0]    o_col,
    output logic [$clog2(REGION_CELLS)-1:0]   o_soff,
    output logic                              o_wr,
    output logic                              o_sel,
    output t_result                           o_res
);

    localparam int OFF_W = $clog2(REGION_CELLS);
    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int EXT_W = $clog2(REGION_CELLS + SCREEN_CELLS + 2 * SCREEN_COLS) + 2;
    localparam int Q_ROWS = SCREEN_CELLS / SCREEN_COLS;
    localparam int R_COLS = SCREEN_CELLS % SCREEN_COLS;
    localparam int SMAX_ROWS = (REGION_CELLS > SCREEN_CELLS) ?
        (REGION_CELLS - SCREEN_CELLS + SCREEN_COLS - 1) / SCREEN_COLS : 0;

    localparam logic signed [EXT_W-1:0] X_ZERO   = '0;
    localparam logic signed [EXT_W-1:0] X_ONE    = EXT_W'(1);
    localparam logic signed [EXT_W-1:0] X_COLS   = EXT_W'(SCREEN_COLS);
    localparam logic signed [EXT_W-1:0] X_REGION = EXT_W'(REGION_CELLS);
    localparam logic signed [EXT_W-1:0] X_QCOLS  = EXT_W'(Q_ROWS * SCREEN_COLS);
    localparam logic signed [EXT_W-1:0] X_SMAX   = EXT_W'(SMAX_ROWS * SCREEN_COLS);
    localparam logic [COL_W-1:0] C_LAST = COL_W'(SCREEN_COLS - 1);
    localparam logic [COL_W-1:0] C_R    = COL_W'(R_COLS);

    logic signed [EXT_W-1:0] off_x;
    logic signed [EXT_W-1:0] col_x;
    logic signed [EXT_W-1:0] soff_x;
    logic signed [EXT_W-1:0] noff_x;
    logic signed [EXT_W-1:0] ncol_x;
    logic signed [EXT_W-1:0] nsoff_x;
    logic signed [EXT_W-1:0] need_x;
    logic signed [EXT_W-1:0] lim_x;
    logic signed [EXT_W-1:0] cell_x;
    logic [COL_W-1:0]        ncol;
    logic                    mem_wr;
    logic [CHAR_W-1:0]       mem_ch;

    always_comb begin
        off_x   = EXT_W'(i_off);
        col_x   = EXT_W'(i_col);
        soff_x  = EXT_W'(i_soff);
        noff_x  = off_x;
        ncol    = i_col;
        nsoff_x = soff_x;
        cell_x  = off_x;
        mem_wr  = 1'b0;
        mem_ch  = i_char;
        ncol_x  = col_x;
        need_x  = X_ZERO;
        lim_x   = X_ZERO;
        case (i_func)
            FUNC_PUT: begin
                if (i_char == CH_NEWLINE) begin
                    if (off_x + X_COLS < X_REGION) begin
                        noff_x = off_x - col_x + X_COLS;
                        ncol   = '0;
                    end
                end else if (i_char == CH_BACKSPACE) begin
                    if (off_x > X_ZERO) begin
                        noff_x = off_x - X_ONE;
                        ncol   = (i_col == '0) ? C_LAST : i_col - COL_W'(1);
                        cell_x = noff_x;
                        mem_wr = 1'b1;
                        mem_ch = CH_SPACE;
                    end
                end else if (off_x + X_ONE < X_REGION) begin
                    noff_x = off_x + X_ONE;
                    ncol   = (i_col == C_LAST) ? '0 : i_col + COL_W'(1);
                    mem_wr = 1'b1;
                end
                // First start row that keeps the cursor on screen, capped at the last row.
                ncol_x = EXT_W'(ncol);
                need_x = noff_x - ncol_x - X_QCOLS + ((ncol >= C_R) ? X_COLS : X_ZERO);
                lim_x  = (need_x < X_SMAX) ? need_x : X_SMAX;
                if (lim_x > soff_x) begin
                    nsoff_x = lim_x;
                end
            end
            FUNC_SCROLL_UP: begin
                if (soff_x > X_ZERO) begin
                    nsoff_x = soff_x - X_COLS;
                end
            end
            FUNC_SCROLL_DOWN: begin
                if (soff_x < X_SMAX) begin
                    nsoff_x = soff_x + X_COLS;
                end
            end
            FUNC_SELECT: begin
                nsoff_x = soff_x;
            end
            default: begin
                nsoff_x = soff_x;
            end
        endcase
    end

    assign o_off  = OFF_W'(noff_x);
    assign o_col  = ncol;
    assign o_soff = OFF_W'(nsoff_x);
    assign o_wr   = i_id_ok && (i_func != FUNC_SELECT);
    assign o_sel  = i_id_ok && (i_func == FUNC_SELECT);

    always_comb begin
        o_res = '0;
        if (i_id_ok) begin
            if (mem_wr) begin
                o_res.mem_write = 1'b1;
                o_res.mem_cell  = i_base + CELL_W'(cell_x);
                o_res.mem_char  = mem_ch;
                o_res.mem_color = i_color;
            end
            if (i_func == FUNC_SELECT || i_k == i_cur) begin
                o_res.crtc_update = 1'b1;
                o_res.crtc_cursor = i_base + CELL_W'(noff_x);
                o_res.crtc_start  = i_base + CELL_W'(nsoff_x);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// Text console cursor and scroll engine
// Keeps cursor and display start of each virtual console in a small RAM and
// produces video memory writes and CRTC updates for each item.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Words
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | i_in_valid/o_in_stall | func, con_num, char_code
//  out      | output    | o_out_valid/i_out_stall | mem_*, crtc_*
//  cfg      | input     | i_cfg_we             | char_color
//
// A word is accepted every cycle unless the input stalls; stage 1 holds it
// and the RAM its state, and the update result is offered from the output
// register. Back-to-back words to the same console take the new state from a
// bypass register instead of the RAM. Reset is synchronous and sets all
// consoles to the base of their region. A stalled output holds its register,
// and the input stalls in that same cycle when a word also waits behind it.
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_scroll import tcc_pkg::*; #(
    parameter int CONSOLE_COUNT = 4,
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_CELLS  = 2000,
    parameter int VIDEO_CELLS   = 16384
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_func,
    input  wire  [ID_W-1:0]    i_con_num,
    input  wire  [CHAR_W-1:0]  i_char_code,
    input  wire                i_cfg_we,
    input  wire  [CHAR_W-1:0]  i_cfg_wdata,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic               o_mem_write,
    output logic [CELL_W-1:0]  o_mem_cell,
    output logic [CHAR_W-1:0]  o_mem_char,
    output logic [CHAR_W-1:0]  o_mem_color,
    output logic               o_crtc_update,
    output logic [CELL_W-1:0]  o_crtc_cursor,
    output logic [CELL_W-1:0]  o_crtc_start
);

    localparam int REGION_CELLS = VIDEO_CELLS / CONSOLE_COUNT;
    localparam int OFF_W = $clog2(REGION_CELLS);
    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int ST_W  = 2 * OFF_W + COL_W;
    localparam int AW    = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;

    function automatic logic [CELL_W-1:0] f_base(input logic [ID_W-1:0] k);
        logic [31:0] full;
        full = 32'(k) * 32'(REGION_CELLS);
        return full[CELL_W-1:0];
    endfunction

    logic              accept;
    logic              s1_adv;
    logic [AW-1:0]     addr_in;
    logic              id_ok_in;

    logic              r_s1_v;
    t_func             r_s1_func;
    logic [ID_W-1:0]   r_s1_k;
    logic [AW-1:0]     r_s1_addr;
    logic [CHAR_W-1:0] r_s1_char;
    logic [CELL_W-1:0] r_s1_base;
    logic              r_s1_idok;
    logic              r_s1_ent_v;
    logic              r_fwd;
    logic [ST_W-1:0]   r_fwd_data;
    logic [2**AW-1:0]  r_valid;
    logic [ID_W-1:0]   r_cur;
    logic [CHAR_W-1:0] r_color;
    logic              r_out_v;
    t_result           r_out;

    logic [ST_W-1:0]   ram_rdata;
    logic [ST_W-1:0]   st;
    logic              ram_we;
    logic [OFF_W-1:0]  upd_off;
    logic [COL_W-1:0]  upd_col;
    logic [OFF_W-1:0]  upd_soff;
    logic              upd_wr;
    logic              upd_sel;
    t_result           upd_res;

    assign s1_adv     = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_s1_v && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign addr_in    = AW'(i_con_num);
    assign id_ok_in   = 32'(i_con_num) < 32'(CONSOLE_COUNT);
    assign ram_we     = s1_adv && upd_wr;

    assign st = r_fwd ? r_fwd_data : (r_s1_ent_v ? ram_rdata : '0);

    tcc_ram #(
        .WIDTH (ST_W),
        .DEPTH (CONSOLE_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata ({upd_off, upd_col, upd_soff}),
        .i_re    (accept),
        .i_raddr (addr_in),
        .o_rdata (ram_rdata)
    );

    tcc_update #(
        .REGION_CELLS (REGION_CELLS),
        .SCREEN_COLS  (SCREEN_COLS),
        .SCREEN_CELLS (SCREEN_CELLS)
    ) u_update (
        .i_func  (r_s1_func),
        .i_id_ok (r_s1_idok),
        .i_k     (r_s1_k),
        .i_cur   (r_cur),
        .i_char  (r_s1_char),
        .i_color (r_color),
        .i_base  (r_s1_base),
        .i_off   (st[ST_W-1 -: OFF_W]),
        .i_col   (st[OFF_W +: COL_W]),
        .i_soff  (st[OFF_W-1:0]),
        .o_off   (upd_off),
        .o_col   (upd_col),
        .o_soff  (upd_soff),
        .o_wr    (upd_wr),
        .o_sel   (upd_sel),
        .o_res   (upd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd   <= 1'b0;
            r_valid <= '0;
            r_cur   <= '0;
            r_color <= COLOR_RESET;
            r_out_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
                r_fwd  <= ram_we && (r_s1_addr == addr_in);
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
                r_fwd  <= 1'b0;
            end
            if (ram_we) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
            if (s1_adv && upd_sel) begin
                r_cur <= r_s1_k;
            end
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func  <= t_func'(i_func);
            r_s1_k     <= i_con_num;
            r_s1_addr  <= addr_in;
            r_s1_char  <= i_char_code;
            r_s1_base  <= f_base(i_con_num);
            r_s1_idok  <= id_ok_in;
            r_s1_ent_v <= r_valid[addr_in];
            r_fwd_data <= {upd_off, upd_col, upd_soff};
        end
        if (s1_adv) begin
            r_out <= upd_res;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_mem_write   = r_out.mem_write;
    assign o_mem_cell    = r_out.mem_cell;
    assign o_mem_char    = r_out.mem_char;
    assign o_mem_color   = r_out.mem_color;
    assign o_crtc_update = r_out.crtc_update;
    assign o_crtc_cursor = r_out.crtc_cursor;
    assign o_crtc_start  = r_out.crtc_start;

    `ASSERT_RST(a_fwd_live, i_clk, i_rst_n, r_fwd |-> r_s1_v, "bypass set without a word in flight")
    `ASSERT_RST(a_s1_hold, i_clk, i_rst_n, (r_s1_v && !s1_adv) |=> (r_s1_v && $stable(r_s1_k)), "stalled word lost")
    `ASSERT_RST(a_cur_range, i_clk, i_rst_n, 32'(r_cur) < 32'(CONSOLE_COUNT), "current console out of range")
    `ASSERT_RST(a_wr_range, i_clk, i_rst_n, ram_we |-> (32'(upd_off) < 32'(REGION_CELLS)), "cursor beyond region")

endmodule

`default_nettype wire
